// File: rtl/core/nmea_wind_sentence_parser_defines.svh
// ----------------------------------------------------------------------------
// nmea wind sentence parser assertion macros
// concurrent check helpers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef NMEA_WIND_SENTENCE_PARSER_DEFINES_SVH
`define NMEA_WIND_SENTENCE_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define NWSP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("nwsp assertion failed");

// next-cycle implication, disabled during reset
`define NWSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("nwsp assertion failed");

`else

`define NWSP_ASSERT_NOW(label, clk, rstn, ante, cons)
`define NWSP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/core/nwsp_pkg.sv
// ----------------------------------------------------------------------------
// nwsp_pkg
// shared types, byte codes and lookup functions of the mwv sentence parser
// ----------------------------------------------------------------------------
package nwsp_pkg;

    // ascii codes used by the parser
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // header length and field widths
    localparam int          HDR_LEN      = 7;
    localparam logic [2:0]  HDR_LAST     = 3'(HDR_LEN - 1);
    localparam int          ANGLE_W      = 16;
    localparam int          SPEED_W      = 17;
    localparam int          FRAC_MAX     = 4;

    // payload field being parsed
    typedef enum logic [1:0] {
        FLD_ANGLE = 2'd0,
        FLD_REF   = 2'd1,
        FLD_SPEED = 2'd2,
        FLD_TRAIL = 2'd3
    } field_t;

    // per-number parse state
    typedef struct packed {
        logic [2:0] frac_cnt;
        logic       seen_point;
        logic       digits_seen;
    } num_state_t;

    // one result beat
    typedef struct packed {
        logic [ANGLE_W-1:0] wind_angle;
        logic [7:0]         reference_char;
        logic [SPEED_W-1:0] wind_speed;
        logic               parse_ok;
    } result_t;

    // expected header byte at a match position
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = CH_I;
            3'd2:    c = CH_I;
            3'd3:    c = CH_M;
            3'd4:    c = CH_W;
            3'd5:    c = CH_V;
            3'd6:    c = CH_COMMA;
            default: c = CH_DOLLAR;
        endcase
        return c;
    endfunction

    // powers of ten for digit weighting
    function automatic logic [13:0] pow10(input logic [2:0] n);
        logic [13:0] p;
        unique case (n)
            3'd0:    p = 14'd1;
            3'd1:    p = 14'd10;
            3'd2:    p = 14'd100;
            3'd3:    p = 14'd1000;
            3'd4:    p = 14'd10000;
            default: p = 14'd1;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/core/nwsp_num_acc.sv
// ----------------------------------------------------------------------------
// nwsp_num_acc
// adds one digit or decimal point to a saturating fixed-point accumulator
// ----------------------------------------------------------------------------
module nwsp_num_acc #(
    parameter int WIDTH       = 16,
    parameter int FRAC_DIGITS = 2
) (
    input  logic [WIDTH-1:0]        acc_i,
    input  logic [7:0]              byte_i,
    input  nwsp_pkg::num_state_t    st_i,
    output logic [WIDTH-1:0]        acc_o,
    output nwsp_pkg::num_state_t    st_o,
    output logic                    bad_o
);
    import nwsp_pkg::*;

    localparam int         FD     = (FRAC_DIGITS > FRAC_MAX) ? FRAC_MAX : FRAC_DIGITS;
    localparam logic [2:0] FD_L   = 3'(FD);
    localparam int         SUM_W  = WIDTH + 5;
    localparam logic [SUM_W-1:0] MAXV = SUM_W'({WIDTH{1'b1}});

    logic [3:0]       digit;
    logic [2:0]       weight_idx;
    logic [17:0]      scaled;
    logic [SUM_W-1:0] acc_ext;
    logic [SUM_W-1:0] sum;

    assign digit      = byte_i[3:0];
    assign acc_ext    = SUM_W'(acc_i);
    assign weight_idx = st_i.seen_point ? (FD_L - st_i.frac_cnt - 3'd1) : FD_L;
    assign scaled     = 18'(digit) * 18'(pow10(weight_idx));

    // digit weighting and saturation
    always_comb begin
        st_o  = st_i;
        bad_o = 1'b0;
        sum   = acc_ext;
        if (byte_i == CH_POINT) begin
            if (st_i.seen_point) begin
                bad_o = 1'b1;
            end else begin
                st_o.seen_point = 1'b1;
            end
        end else begin
            st_o.digits_seen = 1'b1;
            if (!st_i.seen_point) begin
                sum = (acc_ext << 3) + (acc_ext << 1) + SUM_W'(scaled);
            end else if (st_i.frac_cnt < FD_L) begin
                st_o.frac_cnt = st_i.frac_cnt + 3'd1;
                sum = acc_ext + SUM_W'(scaled);
            end
        end
        acc_o = (sum > MAXV) ? {WIDTH{1'b1}} : sum[WIDTH-1:0];
    end

endmodule

// File: rtl/core/nwsp_parser.sv
// ----------------------------------------------------------------------------
// nwsp_parser
// header hunt and payload field state, one byte per fire
// ----------------------------------------------------------------------------
`include "nmea_wind_sentence_parser_defines.svh"

module nwsp_parser #(
    parameter int FRAC_DIGITS = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire_i,
    input  logic [7:0]          byte_i,
    output logic                res_valid_o,
    output nwsp_pkg::result_t   res_o
);
    import nwsp_pkg::*;

    logic [2:0]         hdr_pos_reg,   hdr_pos_next;
    logic               in_payload_reg, in_payload_next;
    field_t             field_reg,     field_next;
    logic [ANGLE_W-1:0] angle_reg,     angle_next;
    logic [SPEED_W-1:0] speed_reg,     speed_next;
    num_state_t         num_reg,       num_next;
    logic [7:0]         ref_reg,       ref_next;
    logic               bad_reg,       bad_next;

    logic [ANGLE_W-1:0] angle_acc;
    logic [SPEED_W-1:0] speed_acc;
    num_state_t         angle_st, speed_st;
    logic               angle_bad, speed_bad;
    logic               numch;

    assign numch = ((byte_i >= CH_ZERO) && (byte_i <= CH_NINE)) || (byte_i == CH_POINT);

    nwsp_num_acc #(.WIDTH(ANGLE_W), .FRAC_DIGITS(FRAC_DIGITS)) u_angle_acc (
        .acc_i  (angle_reg),
        .byte_i (byte_i),
        .st_i   (num_reg),
        .acc_o  (angle_acc),
        .st_o   (angle_st),
        .bad_o  (angle_bad)
    );

    nwsp_num_acc #(.WIDTH(SPEED_W), .FRAC_DIGITS(FRAC_DIGITS)) u_speed_acc (
        .acc_i  (speed_reg),
        .byte_i (byte_i),
        .st_i   (num_reg),
        .acc_o  (speed_acc),
        .st_o   (speed_st),
        .bad_o  (speed_bad)
    );

    // result fields straight from current state
    always_comb begin
        res_o.wind_angle     = angle_reg;
        res_o.reference_char = ref_reg;
        res_o.wind_speed     = speed_reg;
        res_o.parse_ok       = !bad_reg && ((field_reg == FLD_TRAIL) ||
                               ((field_reg == FLD_SPEED) && num_reg.digits_seen));
    end

    // next state for one byte
    always_comb begin
        hdr_pos_next    = hdr_pos_reg;
        in_payload_next = in_payload_reg;
        field_next      = field_reg;
        angle_next      = angle_reg;
        speed_next      = speed_reg;
        num_next        = num_reg;
        ref_next        = ref_reg;
        bad_next        = bad_reg;
        res_valid_o     = 1'b0;
        if (fire_i && (byte_i != CH_NUL)) begin
            if (!in_payload_reg) begin
                if (byte_i == hdr_char(hdr_pos_reg)) begin
                    if (hdr_pos_reg == HDR_LAST) begin
                        hdr_pos_next    = 3'd0;
                        in_payload_next = 1'b1;
                    end else begin
                        hdr_pos_next = hdr_pos_reg + 3'd1;
                    end
                end else begin
                    hdr_pos_next = (byte_i == CH_DOLLAR) ? 3'd1 : 3'd0;
                end
            end else if (byte_i == CH_STAR) begin
                res_valid_o     = 1'b1;
                hdr_pos_next    = 3'd0;
                in_payload_next = 1'b0;
                field_next      = FLD_ANGLE;
                angle_next      = '0;
                speed_next      = '0;
                num_next        = '0;
                ref_next        = '0;
                bad_next        = 1'b0;
            end else begin
                unique case (field_reg)
                    FLD_ANGLE: begin
                        if (numch) begin
                            angle_next = angle_acc;
                            num_next   = angle_st;
                            bad_next   = bad_reg | angle_bad;
                        end else if (byte_i == CH_COMMA) begin
                            bad_next   = bad_reg | !num_reg.digits_seen;
                            num_next   = '0;
                            field_next = FLD_REF;
                        end else begin
                            bad_next = 1'b1;
                        end
                    end
                    FLD_REF: begin
                        if (!num_reg.digits_seen) begin
                            ref_next             = byte_i;
                            num_next.digits_seen = 1'b1;
                        end else if (byte_i == CH_COMMA) begin
                            num_next   = '0;
                            field_next = FLD_SPEED;
                        end else begin
                            bad_next = 1'b1;
                        end
                    end
                    FLD_SPEED: begin
                        if (numch) begin
                            speed_next = speed_acc;
                            num_next   = speed_st;
                            bad_next   = bad_reg | speed_bad;
                        end else if (byte_i == CH_COMMA) begin
                            bad_next   = bad_reg | !num_reg.digits_seen;
                            field_next = FLD_TRAIL;
                        end else begin
                            bad_next = 1'b1;
                        end
                    end
                    FLD_TRAIL: begin
                        field_next = FLD_TRAIL;
                    end
                    default: begin
                        field_next = FLD_TRAIL;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_pos_reg    <= 3'd0;
            in_payload_reg <= 1'b0;
            field_reg      <= FLD_ANGLE;
            angle_reg      <= '0;
            speed_reg      <= '0;
            num_reg        <= '0;
            ref_reg        <= '0;
            bad_reg        <= 1'b0;
        end else begin
            hdr_pos_reg    <= hdr_pos_next;
            in_payload_reg <= in_payload_next;
            field_reg      <= field_next;
            angle_reg      <= angle_next;
            speed_reg      <= speed_next;
            num_reg        <= num_next;
            ref_reg        <= ref_next;
            bad_reg        <= bad_next;
        end
    end

    // header hunt never passes the last header byte
    `NWSP_ASSERT_NOW(a_hdr_range, aclk, aresetn, 1'b1, hdr_pos_reg <= HDR_LAST)
    // while hunting, the sentence state is clear
    `NWSP_ASSERT_NOW(a_hunt_clear, aclk, aresetn, !in_payload_reg,
        (field_reg == FLD_ANGLE) && (angle_reg == '0) && (speed_reg == '0) && !bad_reg)
    // in the payload the header counter rests at zero
    `NWSP_ASSERT_NOW(a_payload_hdr, aclk, aresetn, in_payload_reg, hdr_pos_reg == 3'd0)
    // a result rearms the header hunt
    `NWSP_ASSERT_NEXT(a_rearm, aclk, aresetn, res_valid_o, !in_payload_reg)

endmodule

// File: rtl/core/nmea_wind_sentence_parser.sv
// ----------------------------------------------------------------------------
// nmea_wind_sentence_parser
// parses "$IIMWV," sentences into fixed-point wind angle and speed
// ----------------------------------------------------------------------------
// a '*' byte is held in the input register, then its result in the result register
// throughput: one byte per cycle while m_ready is high; a result waiting in the result
//   register holds off parsing, so the input register fills and s_ready drops
// reset: synchronous active-low aresetn clears both registers' valid bits and the
//   parse state; the block then hunts for the header
module nmea_wind_sentence_parser #(
    parameter int FRAC_DIGITS = 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [nwsp_pkg::ANGLE_W-1:0]    m_wind_angle,
    output logic [7:0]                      m_reference_char,
    output logic [nwsp_pkg::SPEED_W-1:0]    m_wind_speed,
    output logic                            m_parse_ok
);
    import nwsp_pkg::*;

    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       out_vld_reg, out_vld_next;
    result_t    out_reg;
    logic       fire;
    logic       res_valid;
    result_t    res;

    // a stored byte is processed when the result register can take a beat
    assign fire    = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || fire;

    nwsp_parser #(.FRAC_DIGITS(FRAC_DIGITS)) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire_i      (fire),
        .byte_i      (in_byte_reg),
        .res_valid_o (res_valid),
        .res_o       (res)
    );

    // valid bits of input and result registers
    always_comb begin
        in_vld_next = s_ready ? s_valid : in_vld_reg;
        if (fire) begin
            out_vld_next = res_valid;
        end else begin
            out_vld_next = out_vld_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
        if (fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_wind_angle     = out_reg.wind_angle;
    assign m_reference_char = out_reg.reference_char;
    assign m_wind_speed     = out_reg.wind_speed;
    assign m_parse_ok       = out_reg.parse_ok;

endmodule
